### rtl/audio_peak_level_meter_defines.svh
// ----------------------------------------------------------------------------
// audio peak level meter assertion macros
// shared concurrent assertion forms, clocked on the rising edge and
// held off while reset is asserted
// ----------------------------------------------------------------------------
`ifndef AUDIO_PEAK_LEVEL_METER_DEFINES_SVH
`define AUDIO_PEAK_LEVEL_METER_DEFINES_SVH

// same-cycle implication
`define APLM_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("aplm same-cycle check failed");

// next-cycle implication
`define APLM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("aplm next-cycle check failed");

`endif

### rtl/aplm_pkg.sv
// ----------------------------------------------------------------------------
// aplm_pkg
// widths, reset values, register indexes and level thresholds of the
// audio peak level meter
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package aplm_pkg;

    // sample width default
    localparam int SAMPLE_BITS_DEF = 16;

    // register and field widths
    localparam int GAIN_W     = 4;
    localparam int PEAK_W     = 13;
    localparam int DECAY_W    = 4;
    localparam int LEVEL_W    = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;

    // register reset values
    localparam logic [GAIN_W-1:0]  GAIN_SHIFT_RST  = GAIN_W'(6);
    localparam logic [PEAK_W-1:0]  CLAMP_LIMIT_RST = PEAK_W'(8000);
    localparam logic [DECAY_W-1:0] DECAY_SHIFT_RST = DECAY_W'(10);

    // register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GAIN_SHIFT  = 2'd0,
        CFG_CLAMP_LIMIT = 2'd1,
        CFG_DECAY_SHIFT = 2'd2
    } cfg_index_t;

    // level thresholds, ascending
    localparam int NUM_THR = 9;
    localparam logic [PEAK_W-1:0] LEVEL_THRESH [NUM_THR] = '{
        PEAK_W'(1000), PEAK_W'(2000), PEAK_W'(2400), PEAK_W'(2800), PEAK_W'(3000),
        PEAK_W'(3200), PEAK_W'(3600), PEAK_W'(4200), PEAK_W'(5000)
    };

    // level is the count of thresholds at or below the peak
    function automatic logic [LEVEL_W-1:0] level_of(input logic [PEAK_W-1:0] p);
        logic [LEVEL_W-1:0] n;
        n = '0;
        for (int i = 0; i < NUM_THR; i++)
        begin
            if (p >= LEVEL_THRESH[i])
            begin
                n = n + 1'b1;
            end
        end
        return n;
    endfunction

endpackage

### rtl/aplm_channels.sv
// ----------------------------------------------------------------------------
// aplm channels
// valid/ready stream interfaces for the sample input and the meter output
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface aplm_sample_if #(
    parameter int SAMPLE_BITS = aplm_pkg::SAMPLE_BITS_DEF
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

interface aplm_meter_if;
    logic                             valid;
    logic                             ready;
    logic [aplm_pkg::PEAK_W-1:0]      peak_value;
    logic [aplm_pkg::LEVEL_W-1:0]     level;

    modport source (output valid, output peak_value, output level, input ready);
    modport sink   (input valid, input peak_value, input level, output ready);
endinterface

### rtl/audio_peak_level_meter.sv
// ----------------------------------------------------------------------------
// audio_peak_level_meter
// peak detector with proportional decay and a 0..9 loudness level
// ----------------------------------------------------------------------------
//  channel  | dir | fields                  | transfer when
//  mic      | in  | sample                  | mic.valid & mic.ready
//  meter    | out | peak_value, level       | meter.valid & meter.ready
//  cfg      | in  | cfg_index, cfg_data     | cfg_we
//
//  one sample per cycle sustained while the meter output is not stalled; a
//  sample passes s1_valid_reg, then out_valid_reg before meter valid rises
//  stage one registers the scaled and clamped magnitude, stage two applies
//  the decay and peak update, with the held peak fed back from held_peak_reg
//  reset clears the valids, the held peak and loads the register defaults
//  a stalled meter output holds; stage one still takes a sample when empty
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "audio_peak_level_meter_defines.svh"

module audio_peak_level_meter #(
    parameter int SAMPLE_BITS = aplm_pkg::SAMPLE_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    aplm_sample_if.sink                        mic,
    aplm_meter_if.source                       meter,
    input  logic                               cfg_we,
    input  logic [aplm_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [aplm_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int PEAK_W  = aplm_pkg::PEAK_W;
    localparam int SHIFT_W = SAMPLE_BITS + (1 << aplm_pkg::GAIN_W) - 1;

    // configuration registers
    logic [aplm_pkg::GAIN_W-1:0]  gain_shift_reg;
    logic [PEAK_W-1:0]            clamp_limit_reg;
    logic [aplm_pkg::DECAY_W-1:0] decay_shift_reg;

    // pipeline registers
    logic                         s1_valid_reg;
    logic [PEAK_W-1:0]            s1_scaled_reg;
    logic                         out_valid_reg;
    logic [PEAK_W-1:0]            held_peak_reg;
    logic [aplm_pkg::LEVEL_W-1:0] level_reg;

    // handshake
    logic s2_load;
    logic s1_load;

    // stage one datapath
    logic [SAMPLE_BITS-1:0] mag;
    logic [SHIFT_W-1:0]     scaled_wide;
    logic [PEAK_W-1:0]      s1_scaled_next;

    // stage two datapath
    logic [PEAK_W:0]        drop;
    logic [PEAK_W-1:0]      decayed;
    logic [PEAK_W-1:0]      held_peak_next;

    // register writes, unknown indexes fall through
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_shift_reg  <= aplm_pkg::GAIN_SHIFT_RST;
            clamp_limit_reg <= aplm_pkg::CLAMP_LIMIT_RST;
            decay_shift_reg <= aplm_pkg::DECAY_SHIFT_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                aplm_pkg::CFG_GAIN_SHIFT:  gain_shift_reg  <= cfg_data[aplm_pkg::GAIN_W-1:0];
                aplm_pkg::CFG_CLAMP_LIMIT: clamp_limit_reg <= cfg_data[PEAK_W-1:0];
                aplm_pkg::CFG_DECAY_SHIFT: decay_shift_reg <= cfg_data[aplm_pkg::DECAY_W-1:0];
                default: ;
            endcase
        end
    end

    // flow control
    assign s2_load   = s1_valid_reg && (!out_valid_reg || meter.ready);
    assign s1_load   = mic.valid && mic.ready;
    assign mic.ready = !s1_valid_reg || s2_load;

    // magnitude, lossless gain shift, clamp
    always_comb
    begin
        mag         = mic.sample[SAMPLE_BITS-1] ? (~mic.sample + 1'b1) : mic.sample;
        scaled_wide = SHIFT_W'(mag) << gain_shift_reg;
        if (scaled_wide > SHIFT_W'(clamp_limit_reg))
        begin
            s1_scaled_next = clamp_limit_reg;
        end
        else
        begin
            s1_scaled_next = scaled_wide[PEAK_W-1:0];
        end
    end

    // decay the held peak, then take the larger of it and the new sample
    always_comb
    begin
        drop    = (PEAK_W + 1)'(held_peak_reg >> decay_shift_reg) + 1'b1;
        decayed = held_peak_reg;
        if (held_peak_reg > PEAK_W'(1))
        begin
            if (drop >= {1'b0, held_peak_reg})
            begin
                decayed = '0;
            end
            else
            begin
                decayed = held_peak_reg - drop[PEAK_W-1:0];
            end
        end
        held_peak_next = (s1_scaled_reg > decayed) ? s1_scaled_reg : decayed;
    end

    // stage valids and held peak
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            held_peak_reg <= '0;
        end
        else
        begin
            if (mic.ready)
            begin
                s1_valid_reg <= mic.valid;
            end
            if (s2_load)
            begin
                out_valid_reg <= 1'b1;
                held_peak_reg <= held_peak_next;
            end
            else if (meter.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (s1_load)
        begin
            s1_scaled_reg <= s1_scaled_next;
        end
        if (s2_load)
        begin
            level_reg <= aplm_pkg::level_of(held_peak_next);
        end
    end

    // output drive
    assign meter.valid      = out_valid_reg;
    assign meter.peak_value = held_peak_reg;
    assign meter.level      = level_reg;

    // checks
    `APLM_ASSERT_SAME(a_level_matches_peak, clk, rst_n, out_valid_reg,
        level_reg == aplm_pkg::level_of(held_peak_reg))
    `APLM_ASSERT_NEXT(a_peak_rise_from_sample, clk, rst_n, s2_load,
        held_peak_reg <= $past(held_peak_reg) || held_peak_reg == $past(s1_scaled_reg))
    `APLM_ASSERT_NEXT(a_stage_one_holds, clk, rst_n,
        s1_valid_reg && out_valid_reg && !meter.ready,
        s1_valid_reg && $stable(s1_scaled_reg))
    `APLM_ASSERT_SAME(a_scaled_within_clamp, clk, rst_n, s1_valid_reg,
        s1_scaled_reg <= clamp_limit_reg)

endmodule
